@@ design/cfc_pkg.sv @@
// Shared types, constants and CRC functions for the CRC-32 frame checker.
package cfc_pkg;

    localparam int unsigned CRC_W     = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned MODEL_W   = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = MODEL_W;
    localparam int unsigned SEEN_W    = 3;

    localparam logic [CRC_W-1:0]  CRC_POLY = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0]  CRC_ONES = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0]  CRC_ZERO = 32'h0000_0000;
    localparam logic [SEEN_W-1:0] SEEN_MAX = 3'd5;

    typedef enum logic [MODEL_W-1:0] {
        MODEL_REFLECTED = 2'd0,
        MODEL_MPEG2     = 2'd1,
        MODEL_NONE      = 2'd2
    } model_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODEL      = 1'b0,
        REG_CHECK_MODE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [CRC_W-1:0] crc_value;
        logic             crc_match;
        logic             frame_short;
    } result_t;

    function automatic logic [CRC_W-1:0] crc_init(logic [MODEL_W-1:0] m);
        logic [CRC_W-1:0] v;
        unique case (m)
            MODEL_REFLECTED, MODEL_MPEG2: v = CRC_ONES;
            default:                      v = CRC_ZERO;
        endcase
        return v;
    endfunction

    // One byte through the unreflected CRC register, eight shift-xor steps.
    function automatic logic [CRC_W-1:0] crc_feed(logic [CRC_W-1:0] crc,
                                                  logic [BYTE_W-1:0] data,
                                                  logic [MODEL_W-1:0] m);
        logic [CRC_W-1:0]  c;
        logic [CRC_W-1:0]  poly;
        logic [BYTE_W-1:0] b;
        poly = crc_init(m) & CRC_POLY;
        for (int i = 0; i < BYTE_W; i++) begin
            b[i] = (m == MODEL_REFLECTED) ? data[BYTE_W-1-i] : data[i];
        end
        c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ poly) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [CRC_W-1:0] crc_finish(logic [CRC_W-1:0] crc,
                                                    logic [MODEL_W-1:0] m);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = crc[CRC_W-1-i];
        end
        unique case (m)
            MODEL_REFLECTED: r = r ^ CRC_ONES;
            MODEL_MPEG2:     r = crc;
            default:         r = CRC_ZERO;
        endcase
        return r;
    endfunction

endpackage

@@ design/cfc_in_stage.sv @@
// Input register: holds one accepted word until the frame engine takes it.
module cfc_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cfc_pkg::item_t in_item,
    input  logic          take,
    output logic          held_valid,
    output cfc_pkg::item_t held_item
);
    import cfc_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    assign in_ready   = !vld_reg || take;
    assign held_valid = vld_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ design/cfc_engine.sv @@
// Frame engine: running CRC, four-byte holdback line, byte count and result logic.
module cfc_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  cfc_pkg::item_t               item,
    input  logic [cfc_pkg::MODEL_W-1:0]  model,
    input  logic                         check_mode,
    input  logic                         restart,
    input  logic [cfc_pkg::MODEL_W-1:0]  restart_model,
    output cfc_pkg::result_t             result
);
    import cfc_pkg::*;

    logic [CRC_W-1:0]  running_crc_reg;
    logic [CRC_W-1:0]  running_crc_next;
    logic [BYTE_W-1:0] held_reg [4];
    logic [BYTE_W-1:0] held_next [4];
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;

    logic              past_four;
    logic [BYTE_W-1:0] feed_byte;
    logic [CRC_W-1:0]  crc_after;
    logic [CRC_W-1:0]  calc;
    logic [CRC_W-1:0]  stored;

    // Four or more bytes already seen: the oldest held byte belongs to the payload.
    assign past_four = (seen_reg >= SEEN_W'(4));
    assign feed_byte = check_mode ? held_reg[0] : item.data;
    assign crc_after = (!check_mode || past_four)
                       ? crc_feed(running_crc_reg, feed_byte, model)
                       : running_crc_reg;
    assign calc      = crc_finish(crc_after, model);
    // Stored CRC is little-endian; the current byte is its top byte.
    assign stored    = {item.data, held_reg[3], held_reg[2], held_reg[1]};

    always_comb
    begin
        if (!check_mode)
        begin
            result.crc_value   = calc;
            result.crc_match   = 1'b0;
            result.frame_short = 1'b0;
        end
        else if (!past_four)
        begin
            result.crc_value   = CRC_ZERO;
            result.crc_match   = 1'b0;
            result.frame_short = 1'b1;
        end
        else
        begin
            result.crc_value   = calc;
            result.crc_match   = (stored == calc);
            result.frame_short = 1'b0;
        end
    end

    always_comb
    begin
        running_crc_next = running_crc_reg;
        held_next        = held_reg;
        seen_next        = seen_reg;
        if (restart)
        begin
            running_crc_next = crc_init(restart_model);
            held_next        = '{default: '0};
            seen_next        = '0;
        end
        else if (step && item.last)
        begin
            running_crc_next = crc_init(model);
            held_next        = '{default: '0};
            seen_next        = '0;
        end
        else if (step)
        begin
            running_crc_next = crc_after;
            if (check_mode)
            begin
                held_next[0] = held_reg[1];
                held_next[1] = held_reg[2];
                held_next[2] = held_reg[3];
                held_next[3] = item.data;
            end
            seen_next = (seen_reg == SEEN_MAX) ? SEEN_MAX : seen_reg + SEEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg <= CRC_ONES;
            held_reg        <= '{default: '0};
            seen_reg        <= '0;
        end
        else
        begin
            running_crc_reg <= running_crc_next;
            held_reg        <= held_next;
            seen_reg        <= seen_next;
        end
    end

endmodule

@@ design/cfc_out_stage.sv @@
// Result register: holds one finished result word until the consumer takes it.
module cfc_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  cfc_pkg::result_t   result_in,
    output logic               free,
    output logic               out_valid,
    input  logic               out_ready,
    output cfc_pkg::result_t   result_out
);
    import cfc_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t result_reg;

    assign free       = !vld_reg || out_ready;
    assign out_valid  = vld_reg;
    assign result_out = result_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

endmodule

@@ design/crc32_frame_check_core.sv @@
// Top level of the CRC-32 frame checker: configuration registers and stage wiring.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   data_byte, last_byte
//   out      out_valid / out_ready crc_value, crc_match, frame_short
//   cfg      cfg_wr_en             cfg_index, cfg_data
//
// One byte word is taken every cycle unless a final byte waits for a free result
// register; the whole byte update is eight unrolled shift-xor steps between the
// input register and the result register. A result follows its final byte through the input and result registers.
// Reset selects the reflected CRC-32 in compute mode with an empty frame.
// A stalled result holds back a final byte and, behind it, all further input.
module crc32_frame_check_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [cfc_pkg::BYTE_W-1:0]      data_byte,
    input  logic                            last_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cfc_pkg::CRC_W-1:0]       crc_value,
    output logic                            crc_match,
    output logic                            frame_short,
    input  logic                            cfg_wr_en,
    input  logic [cfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cfc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cfc_pkg::*;

    logic [MODEL_W-1:0] model_reg;
    logic [MODEL_W-1:0] model_next;
    logic               check_mode_reg;
    logic               check_mode_next;

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    out_free;
    logic    step;
    result_t result;
    result_t result_out;

    assign in_item.data = data_byte;
    assign in_item.last = last_byte;

    // A final byte waits for room in the result register.
    assign step = held_valid && (!held_item.last || out_free);

    always_comb
    begin
        model_next      = model_reg;
        check_mode_next = check_mode_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MODEL:      model_next      = cfg_data[MODEL_W-1:0];
                REG_CHECK_MODE: check_mode_next = cfg_data[0];
                default:        model_next      = model_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg      <= MODEL_REFLECTED;
            check_mode_reg <= 1'b0;
        end
        else
        begin
            model_reg      <= model_next;
            check_mode_reg <= check_mode_next;
        end
    end

    cfc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (step),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    cfc_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .item          (held_item),
        .model         (model_reg),
        .check_mode    (check_mode_reg),
        .restart       (cfg_wr_en),
        .restart_model (model_next),
        .result        (result)
    );

    cfc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step && held_item.last),
        .result_in  (result),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result_out)
    );

    assign crc_value   = result_out.crc_value;
    assign crc_match   = result_out.crc_match;
    assign frame_short = result_out.frame_short;

endmodule
